@@ hw/rtl/packet_deframer_crc_check_core_defines.svh @@
// ----------------------------------------------------------------------------
// Packet deframer assertion macros
// Shared concurrent assertion forms used by the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef PACKET_DEFRAMER_CRC_CHECK_CORE_DEFINES_SVH
`define PACKET_DEFRAMER_CRC_CHECK_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PDCC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PDCC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/pdcc_pkg.sv @@
// ----------------------------------------------------------------------------
// Packet deframer package
// Header layout constants, status codes, result type and CRC-32 byte update.
// ----------------------------------------------------------------------------
package pdcc_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 512;
   localparam int HDR_BYTES           = 12;
   localparam int CRC_BYTES           = 4;
   localparam int LEN_W               = 16;
   // wide enough for a 16-bit length plus header and trailer
   localparam int CMP_W               = 18;

   localparam logic [1:0]  TYPE_NONE = 2'd0;
   localparam logic [1:0]  TYPE_DATA = 2'd1;
   localparam logic [7:0]  HDR0_CRC_MASK = 8'hDF;
   localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_TYPE_ERR    = 3'd1,
      STATUS_LEN_ERR     = 3'd2,
      STATUS_HDR_CRC_ERR = 3'd3,
      STATUS_PLD_CRC_ERR = 3'd4
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      status_type  status;
      logic [1:0]  packet_type;
      logic        truncated_flag;
      logic [4:0]  window_size;
      logic [7:0]  sequence_number;
      logic [9:0]  payload_length;
      logic [31:0] time_stamp;
   } result_type;

   // Reflected CRC-32, one byte
   function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ hw/rtl/pdcc_parser.sv @@
// ----------------------------------------------------------------------------
// Packet deframer parser
// Byte position tracking, header capture, CRC checks and result forming.
// ----------------------------------------------------------------------------
module pdcc_parser #(
   parameter int MAX_PAYLOAD = pdcc_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           data_byte,
   input  logic                 start_req,
   output logic                 res_valid,
   output pdcc_pkg::result_type res
);

   localparam int POS_W = $clog2(MAX_PAYLOAD + pdcc_pkg::HDR_BYTES + pdcc_pkg::CRC_BYTES + 1);
   localparam int LEN_W = pdcc_pkg::LEN_W;
   localparam int CMP_W = pdcc_pkg::CMP_W;

   logic [POS_W-1:0] pos_ff, pos_in, pos_e;
   logic             idle_ff, idle_in, idle_e;
   logic [31:0]      crc_ff, crc_in, crc_e, crc_next;
   logic [31:0]      rcv_ff, rcv_in, rcv_e, rcv_shift;
   logic [7:0]       hdr0_ff, hdr0_in, hdr0_e;
   logic [7:0]       seq_ff, seq_in, seq_e;
   logic [LEN_W-1:0] len_ff, len_in, len_e, len_full;
   logic [31:0]      ts_ff, ts_in, ts_e;
   logic [7:0]       feed_byte;
   logic [CMP_W-1:0] pos_x, len_x;
   logic             finish, emit_pld;
   pdcc_pkg::status_type fin_status;

   always_comb begin
      // a start mark drops any packet in progress
      if (step && start_req) begin
         pos_e  = '0;
         idle_e = 1'b0;
         crc_e  = pdcc_pkg::CRC_INIT;
         rcv_e  = '0;
         hdr0_e = '0;
         seq_e  = '0;
         len_e  = '0;
         ts_e   = '0;
      end else begin
         pos_e  = pos_ff;
         idle_e = idle_ff;
         crc_e  = crc_ff;
         rcv_e  = rcv_ff;
         hdr0_e = hdr0_ff;
         seq_e  = seq_ff;
         len_e  = len_ff;
         ts_e   = ts_ff;
      end

      feed_byte = (pos_e == '0) ? (data_byte & pdcc_pkg::HDR0_CRC_MASK) : data_byte;
      crc_next  = pdcc_pkg::crc32_byte(crc_e, feed_byte);
      rcv_shift = {rcv_e[23:0], data_byte};
      len_full  = {len_e[LEN_W-1:8], data_byte};
      pos_x     = CMP_W'(pos_e);
      len_x     = CMP_W'(len_e);

      pos_in     = pos_e;
      idle_in    = idle_e;
      crc_in     = crc_e;
      rcv_in     = rcv_e;
      hdr0_in    = hdr0_e;
      seq_in     = seq_e;
      len_in     = len_e;
      ts_in      = ts_e;
      finish     = 1'b0;
      emit_pld   = 1'b0;
      fin_status = pdcc_pkg::STATUS_OK;

      if (step && !idle_e) begin
         pos_in = pos_e + POS_W'(1);
         if (pos_e == '0) begin
            hdr0_in = data_byte;
            crc_in  = crc_next;
            if (data_byte[7:6] == pdcc_pkg::TYPE_NONE ||
                (data_byte[5] && data_byte[7:6] != pdcc_pkg::TYPE_DATA)) begin
               finish     = 1'b1;
               fin_status = pdcc_pkg::STATUS_TYPE_ERR;
            end
         end else if (pos_e < POS_W'(8)) begin
            crc_in = crc_next;
            if (pos_e == POS_W'(1)) begin
               seq_in = data_byte;
            end else if (pos_e == POS_W'(2)) begin
               len_in = {data_byte, 8'h00};
            end else if (pos_e == POS_W'(3)) begin
               len_in = len_full;
               if (len_full > LEN_W'(MAX_PAYLOAD)) begin
                  finish     = 1'b1;
                  fin_status = pdcc_pkg::STATUS_LEN_ERR;
               end
            end else begin
               ts_in[{pos_e[1:0], 3'b000} +: 8] = data_byte;
            end
         end else if (pos_e < POS_W'(pdcc_pkg::HDR_BYTES)) begin
            rcv_in = rcv_shift;
            if (pos_e == POS_W'(pdcc_pkg::HDR_BYTES - 1)) begin
               if (~crc_e != rcv_shift) begin
                  finish     = 1'b1;
                  fin_status = pdcc_pkg::STATUS_HDR_CRC_ERR;
               end else if (len_e == '0) begin
                  finish = 1'b1;
               end else begin
                  crc_in = pdcc_pkg::CRC_INIT;
                  rcv_in = '0;
               end
            end
         end else if (pos_x < len_x + CMP_W'(pdcc_pkg::HDR_BYTES)) begin
            crc_in   = crc_next;
            emit_pld = 1'b1;
         end else begin
            rcv_in = rcv_shift;
            if (pos_x == len_x + CMP_W'(pdcc_pkg::HDR_BYTES + pdcc_pkg::CRC_BYTES - 1)) begin
               finish     = 1'b1;
               fin_status = (~crc_e != rcv_shift) ? pdcc_pkg::STATUS_PLD_CRC_ERR
                                                  : pdcc_pkg::STATUS_OK;
            end
         end
         if (finish) begin
            idle_in = 1'b1;
         end
      end

      res_valid           = finish || emit_pld;
      res.kind            = finish ? pdcc_pkg::KIND_STATUS : pdcc_pkg::KIND_PAYLOAD;
      res.payload_byte    = emit_pld ? data_byte : 8'd0;
      res.status          = finish ? fin_status : pdcc_pkg::STATUS_OK;
      res.packet_type     = hdr0_in[7:6];
      res.truncated_flag  = hdr0_in[5];
      res.window_size     = hdr0_in[4:0];
      res.sequence_number = seq_in;
      res.payload_length  = len_in[9:0];
      res.time_stamp      = ts_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         idle_ff <= 1'b1;
         crc_ff  <= pdcc_pkg::CRC_INIT;
         rcv_ff  <= '0;
         hdr0_ff <= '0;
         seq_ff  <= '0;
         len_ff  <= '0;
         ts_ff   <= '0;
      end else begin
         pos_ff  <= pos_in;
         idle_ff <= idle_in;
         crc_ff  <= crc_in;
         rcv_ff  <= rcv_in;
         hdr0_ff <= hdr0_in;
         seq_ff  <= seq_in;
         len_ff  <= len_in;
         ts_ff   <= ts_in;
      end
   end

endmodule

@@ hw/rtl/packet_deframer_crc_check_core.sv @@
// ----------------------------------------------------------------------------
// Packet deframer with CRC-32 header and payload check
// Parses a byte stream into header fields, forwards payload bytes and
// reports a final status per packet.
// ----------------------------------------------------------------------------
//  channel   | ports  | moves
//  ----------+--------+-------------------------------------------------
//  input     | req_*  | one packet byte plus start mark per transaction
//  result    | rsp_*  | payload byte or final packet status per transaction
//
// One byte per cycle sustained while rsp_ready stays high; rsp_valid rises once its
// byte has passed the input register and then the result register, with the
// byte-wide CRC-32 update and field capture between those registers.
// Reset is synchronous; no clearing pass, the block is ready right after it.
// A stall on rsp_ready holds the result register and backs up into the
// input register, which then drops req_ready.
// ----------------------------------------------------------------------------
`include "packet_deframer_crc_check_core_defines.svh"

module packet_deframer_crc_check_core #(
   parameter int MAX_PAYLOAD = pdcc_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_req,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [2:0]  rsp_status,
   output logic [1:0]  rsp_packet_type,
   output logic        rsp_truncated_flag,
   output logic [4:0]  rsp_window_size,
   output logic [7:0]  rsp_sequence_number,
   output logic [9:0]  rsp_payload_length,
   output logic [31:0] rsp_time_stamp
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_data_ff;
   logic                 in_start_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   pdcc_pkg::result_type rsp_res_ff;
   pdcc_pkg::result_type res;
   logic                 res_valid;
   logic                 go;

   // the held byte moves on when the result slot is free or being drained
   assign go        = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || go;

   pdcc_parser #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (go),
      .data_byte (in_data_ff),
      .start_req (in_start_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (go) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (go && res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_valid && req_ready) begin
         in_data_ff  <= req_data_byte;
         in_start_ff <= req_start_req;
      end
      if (go && res_valid) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_res_ff.kind;
   assign rsp_payload_byte    = rsp_res_ff.payload_byte;
   assign rsp_status          = rsp_res_ff.status;
   assign rsp_packet_type     = rsp_res_ff.packet_type;
   assign rsp_truncated_flag  = rsp_res_ff.truncated_flag;
   assign rsp_window_size     = rsp_res_ff.window_size;
   assign rsp_sequence_number = rsp_res_ff.sequence_number;
   assign rsp_payload_length  = rsp_res_ff.payload_length;
   assign rsp_time_stamp      = rsp_res_ff.time_stamp;

   // payload bytes only exist for packets with a nonzero length
   `PDCC_ASSERT_SAME(a_pld_has_length, clock, reset,
      rsp_valid && rsp_kind == pdcc_pkg::KIND_PAYLOAD,
      rsp_payload_length != 10'd0 && rsp_status == pdcc_pkg::STATUS_OK,
      "payload transaction without a header length")

   // a type error must match the captured header byte
   `PDCC_ASSERT_SAME(a_type_err_fields, clock, reset,
      rsp_valid && rsp_kind == pdcc_pkg::KIND_STATUS &&
      rsp_status == pdcc_pkg::STATUS_TYPE_ERR,
      rsp_packet_type == pdcc_pkg::TYPE_NONE ||
      (rsp_truncated_flag && rsp_packet_type != pdcc_pkg::TYPE_DATA),
      "type error reported for a valid header byte")

   // a byte stuck behind a full result slot is not lost
   `PDCC_ASSERT_NEXT(a_in_hold, clock, reset,
      in_valid_ff && rsp_valid_ff && !rsp_ready,
      in_valid_ff && $stable(in_data_ff) && $stable(in_start_ff),
      "held input byte lost during result stall")

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// Packet deframer testbench
// Streams framed packets through the deframer under random valid/ready
// gaps and checks every payload byte and packet status against a
// cycle-free model of the header parse and CRC-32 checks.
// ----------------------------------------------------------------------------
module tb_top;
   import pdcc_pkg::*;

   localparam int MAX_LEN   = MAX_PAYLOAD_DEFAULT;
   localparam int HDR_FIXED = 8;   // header bytes covered by the header CRC

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_start_req = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_payload_byte;
   logic [2:0]  rsp_status;
   logic [1:0]  rsp_packet_type;
   logic        rsp_truncated_flag;
   logic [4:0]  rsp_window_size;
   logic [7:0]  rsp_sequence_number;
   logic [9:0]  rsp_payload_length;
   logic [31:0] rsp_time_stamp;

   packet_deframer_crc_check_core u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_start_req       (req_start_req),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_status          (rsp_status),
      .rsp_packet_type     (rsp_packet_type),
      .rsp_truncated_flag  (rsp_truncated_flag),
      .rsp_window_size     (rsp_window_size),
      .rsp_sequence_number (rsp_sequence_number),
      .rsp_payload_length  (rsp_payload_length),
      .rsp_time_stamp      (rsp_time_stamp)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Deframer model state
   int unsigned rx_pos;
   bit          rx_idle;
   logic [31:0] rx_crc;
   logic [31:0] rx_fcs;
   logic [7:0]  hdr0;
   logic [7:0]  hdr_seq;
   logic [15:0] hdr_len;
   logic [31:0] hdr_ts;

   result_type  want_q[$];
   logic [7:0]  frame_q[$];
   int          err_count = 0;
   int          stall_cnt = 0;
   int          items_sent = 0;
   bit          no_idle = 1'b0;

   // Bit-serial reflected CRC-32 update
   function automatic logic [31:0] crc_next(logic [31:0] c, logic [7:0] d);
      logic fb;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ d[i];
         c  = c >> 1;
         if (fb) c = c ^ CRC_POLY;
      end
      return c;
   endfunction

   function automatic void clear_frame_state();
      rx_pos  = 0;
      rx_crc  = CRC_INIT;
      rx_fcs  = '0;
      hdr0    = '0;
      hdr_seq = '0;
      hdr_len = '0;
      hdr_ts  = '0;
   endfunction

   function automatic result_type make_result(kind_type k, logic [7:0] b, status_type s);
      result_type r;
      r.kind            = k;
      r.payload_byte    = b;
      r.status          = s;
      r.packet_type     = hdr0[7:6];
      r.truncated_flag  = hdr0[5];
      r.window_size     = hdr0[4:0];
      r.sequence_number = hdr_seq;
      r.payload_length  = hdr_len[9:0];
      r.time_stamp      = hdr_ts;
      return r;
   endfunction

   function automatic result_type end_frame(status_type s);
      rx_idle = 1'b1;
      return make_result(KIND_STATUS, 8'h00, s);
   endfunction

   // Advance the model by one accepted byte; returns 1 when a result is due
   function automatic bit deframe_step(logic [7:0] b, bit sop, output result_type r);
      int unsigned p;
      int unsigned off;
      logic [15:0] len;
      r = '0;
      if (sop) begin
         clear_frame_state();
         rx_idle = 1'b0;
      end
      if (rx_idle) return 1'b0;
      p      = rx_pos;
      len    = hdr_len;
      rx_pos = p + 1;
      if (p == 0) begin
         hdr0   = b;
         rx_crc = crc_next(rx_crc, b & HDR0_CRC_MASK);
         if (b[7:6] == TYPE_NONE || (b[5] && b[7:6] != TYPE_DATA)) begin
            r = end_frame(STATUS_TYPE_ERR);
            return 1'b1;
         end
         return 1'b0;
      end
      if (p < HDR_FIXED) begin
         rx_crc = crc_next(rx_crc, b);
         if (p == 1) hdr_seq = b;
         else if (p == 2) hdr_len = {b, 8'h00};
         else if (p == 3) begin
            hdr_len[7:0] = b;
            if (hdr_len > MAX_LEN) begin
               r = end_frame(STATUS_LEN_ERR);
               return 1'b1;
            end
         end else hdr_ts = hdr_ts | (32'(b) << (8 * (p - 4)));
         return 1'b0;
      end
      if (p < HDR_BYTES) begin
         rx_fcs = {rx_fcs[23:0], b};
         if (p == HDR_BYTES - 1) begin
            if (~rx_crc != rx_fcs) begin
               r = end_frame(STATUS_HDR_CRC_ERR);
               return 1'b1;
            end
            if (len == 0) begin
               r = end_frame(STATUS_OK);
               return 1'b1;
            end
            rx_crc = CRC_INIT;
            rx_fcs = '0;
         end
         return 1'b0;
      end
      off = p - HDR_BYTES;
      if (off < len) begin
         rx_crc = crc_next(rx_crc, b);
         r = make_result(KIND_PAYLOAD, b, STATUS_OK);
         return 1'b1;
      end
      rx_fcs = {rx_fcs[23:0], b};
      if (off == len + CRC_BYTES - 1) begin
         r = end_frame((~rx_crc != rx_fcs) ? STATUS_PLD_CRC_ERR : STATUS_OK);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 50);
   endfunction

   function automatic string fmt_result(result_type r);
      return $sformatf({"kind=%0d byte=%02h st=%0d typ=%0d tr=%0d win=%0d ",
                        "seq=%02h len=%0d ts=%08h"},
                       r.kind, r.payload_byte, r.status, r.packet_type, r.truncated_flag,
                       r.window_size, r.sequence_number, r.payload_length, r.time_stamp);
   endfunction

   // Frame image: header, header CRC, then payload and payload CRC if 0 < len <= MAX_LEN
   function automatic void build_frame(logic [7:0] b0, logic [7:0] seq, logic [15:0] len,
                                       logic [31:0] ts, bit bad_hdr, bit bad_pld);
      logic [31:0] c;
      logic [7:0]  d;
      frame_q.delete();
      frame_q = '{b0, seq, len[15:8], len[7:0], ts[7:0], ts[15:8], ts[23:16], ts[31:24]};
      c = crc_next(CRC_INIT, b0 & HDR0_CRC_MASK);
      for (int i = 1; i < HDR_FIXED; i++) c = crc_next(c, frame_q[i]);
      c = ~c;
      if (bad_hdr) c = c ^ (32'd1 << $urandom_range(0, 31));
      for (int i = 3; i >= 0; i--) frame_q.push_back(c[8*i +: 8]);
      if (len == 0 || len > MAX_LEN) return;
      c = CRC_INIT;
      for (int i = 0; i < len; i++) begin
         d = 8'($urandom_range(0, 255));
         frame_q.push_back(d);
         c = crc_next(c, d);
      end
      c = ~c;
      if (bad_pld) c = c ^ (32'd1 << $urandom_range(0, 31));
      for (int i = 3; i >= 0; i--) frame_q.push_back(c[8*i +: 8]);
   endfunction

   // One byte transaction; the model is stepped at the accepting edge
   task automatic send_byte(logic [7:0] d, bit sop);
      result_type r;
      int gap;
      req_valid     <= 1'b1;
      req_data_byte <= d;
      req_start_req <= sop;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (deframe_step(d, sop, r)) want_q.push_back(r);
      gap = (no_idle || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_frame(int n);
      for (int i = 0; i < n; i++) send_byte(frame_q[i], i == 0);
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (want_q.size() != 0) @(posedge clock);
   endtask

   // Result side back-pressure
   always @(posedge clock) begin
      if (stall_cnt != 0) begin
         stall_cnt <= stall_cnt - 1;
         rsp_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
         stall_cnt <= pick_gap() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      bit bad;
      if (!reset && rsp_valid && rsp_ready) begin
         got.kind            = kind_type'(rsp_kind);
         got.payload_byte    = rsp_payload_byte;
         got.status          = status_type'(rsp_status);
         got.packet_type     = rsp_packet_type;
         got.truncated_flag  = rsp_truncated_flag;
         got.window_size     = rsp_window_size;
         got.sequence_number = rsp_sequence_number;
         got.payload_length  = rsp_payload_length;
         got.time_stamp      = rsp_time_stamp;
         if (want_q.size() == 0) begin
            err_count++;
            if (err_count <= 10) $display("unexpected result: %s", fmt_result(got));
         end else begin
            want = want_q.pop_front();
            bad = (got.kind !== want.kind) || (got.payload_byte !== want.payload_byte) ||
                  (got.status !== want.status) || (got.packet_type !== want.packet_type) ||
                  (got.truncated_flag !== want.truncated_flag) ||
                  (got.window_size !== want.window_size) ||
                  (got.sequence_number !== want.sequence_number) ||
                  (got.payload_length !== want.payload_length) ||
                  (got.time_stamp !== want.time_stamp);
            if (bad) begin
               err_count++;
               if (err_count <= 10) begin
                  $display("mismatch at %0t", $realtime);
                  $display("  expected %s", fmt_result(want));
                  $display("  actual   %s", fmt_result(got));
               end
            end
         end
      end
   end

   // Type rejects: type 0, truncation on non-data types, then a stray byte while idle
   task automatic test_type_checks();
      send_byte({TYPE_NONE, 6'h00}, 1'b1);
      send_byte({2'($urandom_range(2, 3)), 1'b1, 5'h00}, 1'b1);
      send_byte({2'($urandom_range(2, 3)), 1'b1, 5'h1F}, 1'b1);
      send_byte(8'hA5, 1'b0);
      wait_all_results();
   endtask

   task automatic test_length_checks();
      build_frame({TYPE_DATA, 1'b0, 5'h0A}, 8'hFF, 16'hFFFF, 32'h0, 1'b0, 1'b0);
      send_frame(4);
      build_frame({TYPE_DATA, 1'b1, 5'h15}, 8'h00, 16'(MAX_LEN + 1), 32'h0, 1'b0, 1'b0);
      send_frame(4);
      wait_all_results();
   endtask

   // Header-only packet; truncated bit set must not enter the header CRC
   task automatic test_zero_length();
      build_frame({TYPE_DATA, 1'b1, 5'h1F}, 8'hFF, 16'h0000, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_frame(frame_q.size());
      wait_all_results();
   endtask

   task automatic test_max_length();
      build_frame({2'd3, 1'b0, 5'h00}, 8'h5A, 16'(MAX_LEN), 32'h1234_5678, 1'b0, 1'b0);
      send_frame(frame_q.size());
      wait_all_results();
   endtask

   task automatic test_random_traffic();
      int pick;
      int cut;
      logic [7:0]  b0;
      logic [15:0] len;
      while (items_sent < 650) begin
         no_idle = ($urandom_range(0, 4) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
            continue;
         end
         len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(17, 80))
                                           : 16'($urandom_range(0, 16));
         b0 = {2'($urandom_range(1, 3)), 1'b0, 5'($urandom_range(0, 31))};
         if (b0[7:6] == TYPE_DATA) b0[5] = 1'($urandom_range(0, 1));
         if (pick < 14) begin
            if ($urandom_range(0, 1)) b0[7:6] = TYPE_NONE;
            else b0[7:6] = 2'($urandom_range(2, 3));
            b0[5] = b0[5] | (b0[7:6] != TYPE_NONE);
         end else if (pick < 20) begin
            len = 16'($urandom_range(MAX_LEN + 1, 65535));
         end
         build_frame(b0, 8'($urandom_range(0, 255)), len, 32'($urandom),
                     pick >= 20 && pick < 30, pick >= 30 && pick < 40);
         cut = frame_q.size();
         // restart: the next start mark lands in the middle of this packet
         if (pick >= 40 && pick < 48) cut = $urandom_range(1, frame_q.size() - 1);
         send_frame(cut);
         if ($urandom_range(0, 24) == 0) wait_all_results();
      end
      no_idle = 1'b0;
      wait_all_results();
   endtask

   initial begin
      clear_frame_state();
      rx_idle = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_type_checks();
      test_length_checks();
      test_zero_length();
      test_max_length();
      test_random_traffic();
      wait_all_results();
      repeat (10) @(posedge clock);
      if (err_count == 0 && want_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
